[rtl/core/rgbf_pkg.sv]
// ----------------------------------------------------------------------------
// rgbf_pkg
// Shared types, constants and the gamma table for the rgb gamma fade controller.
// ----------------------------------------------------------------------------
package rgbf_pkg;

	localparam int GAMMA_ENTRIES = 256;
	localparam int PWM_BITS      = 16;
	localparam int LEVEL_W       = 8;
	localparam int DIV_W         = 13;
	localparam int DIV_STEPS     = LEVEL_W;
	localparam int CNT_W         = $clog2(DIV_STEPS);
	localparam int LANES         = 3;
	localparam int TIME_W        = 16;
	localparam int RECIP_W       = 17;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;
	localparam int RECIP_SHIFT   = 19;
	localparam logic [LEVEL_W-2:0] STEP_MAX = 7'd127;
	localparam logic [LEVEL_W-1:0] PRESCALE_RESET = 8'd2;

	typedef enum logic [1:0] {
		CMD_SET  = 2'd0,
		CMD_FADE = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_IDLE = 2'd1,
		MODE_FADE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [LEVEL_W-1:0] red_in;
		logic [LEVEL_W-1:0] green_in;
		logic [LEVEL_W-1:0] blue_in;
		logic [TIME_W-1:0]  fade_time;
	} in_item_t;

	typedef struct packed {
		logic [PWM_BITS-1:0] pwm_red;
		logic [PWM_BITS-1:0] pwm_green;
		logic [PWM_BITS-1:0] pwm_blue;
		logic [1:0]          mode_out;
	} out_item_t;

	typedef struct packed {
		logic set;
		logic div_load;
		logic div_step;
		logic div_last;
		logic tick_apply;
		logic snap;
	} lane_ctrl_t;

	localparam logic [15:0] GAMMA_LUT [256] = '{
		16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd2,
		16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd3,
		16'd3, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3, 16'd4, 16'd4, 16'd4, 16'd4, 16'd4,
		16'd4, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd6, 16'd6, 16'd6, 16'd6, 16'd7,
		16'd7, 16'd7, 16'd8, 16'd8, 16'd8, 16'd9, 16'd9, 16'd10, 16'd10, 16'd10,
		16'd11, 16'd11, 16'd12, 16'd12, 16'd13, 16'd13, 16'd14, 16'd15,
		16'd15, 16'd16, 16'd17, 16'd17, 16'd18, 16'd19, 16'd20, 16'd21, 16'd22,
		16'd23, 16'd24, 16'd25, 16'd26, 16'd27, 16'd28, 16'd29,
		16'd31, 16'd32, 16'd33, 16'd35, 16'd36, 16'd38, 16'd40, 16'd41, 16'd43,
		16'd45, 16'd47, 16'd49, 16'd52, 16'd54, 16'd56, 16'd59,
		16'd61, 16'd64, 16'd67, 16'd70, 16'd73, 16'd76, 16'd79, 16'd83, 16'd87,
		16'd91, 16'd95, 16'd99, 16'd103, 16'd108, 16'd112,
		16'd117, 16'd123, 16'd128, 16'd134, 16'd140, 16'd146, 16'd152, 16'd159,
		16'd166, 16'd173, 16'd181, 16'd189, 16'd197,
		16'd206, 16'd215, 16'd225, 16'd235, 16'd245, 16'd256, 16'd267, 16'd279,
		16'd292, 16'd304, 16'd318, 16'd332, 16'd347,
		16'd362, 16'd378, 16'd395, 16'd412, 16'd431, 16'd450, 16'd470, 16'd490,
		16'd512, 16'd535, 16'd558, 16'd583, 16'd609,
		16'd636, 16'd664, 16'd693, 16'd724, 16'd756, 16'd790, 16'd825, 16'd861,
		16'd899, 16'd939, 16'd981, 16'd1024, 16'd1069,
		16'd1117, 16'd1166, 16'd1218, 16'd1272, 16'd1328, 16'd1387, 16'd1448,
		16'd1512, 16'd1579, 16'd1649, 16'd1722,
		16'd1798, 16'd1878, 16'd1961, 16'd2048, 16'd2139, 16'd2233, 16'd2332,
		16'd2435, 16'd2543, 16'd2656, 16'd2773,
		16'd2896, 16'd3025, 16'd3158, 16'd3298, 16'd3444, 16'd3597, 16'd3756,
		16'd3922, 16'd4096, 16'd4277, 16'd4467,
		16'd4664, 16'd4871, 16'd5087, 16'd5312, 16'd5547, 16'd5793, 16'd6049,
		16'd6317, 16'd6596, 16'd6889, 16'd7194,
		16'd7512, 16'd7845, 16'd8192, 16'd8555, 16'd8933, 16'd9329, 16'd9742,
		16'd10173, 16'd10624, 16'd11094,
		16'd11585, 16'd12098, 16'd12634, 16'd13193, 16'd13777, 16'd14387,
		16'd15024, 16'd15689, 16'd16384,
		16'd17109, 16'd17867, 16'd18658, 16'd19484, 16'd20346, 16'd21247,
		16'd22188, 16'd23170, 16'd24196,
		16'd25267, 16'd26386, 16'd27554, 16'd28774, 16'd30048, 16'd31378,
		16'd32768, 16'd34218, 16'd35733,
		16'd37315, 16'd38967, 16'd40693, 16'd42494, 16'd44376, 16'd46340,
		16'd48392, 16'd50534, 16'd52772,
		16'd55108, 16'd57548, 16'd60096, 16'd62757, 16'd65535
	};

	function automatic logic [PWM_BITS-1:0] pwm_value(input logic [LEVEL_W-1:0] level);
		logic [LEVEL_W-1:0] idx;
		logic [15:0]        g;
		if (int'(level) > GAMMA_ENTRIES - 1) begin
			idx = LEVEL_W'(GAMMA_ENTRIES - 1);
		end else begin
			idx = level;
		end
		g = GAMMA_LUT[idx] >> (16 - PWM_BITS);
		return ~g[PWM_BITS-1:0];
	endfunction

endpackage

[rtl/core/rgbf_lane.sv]
// ----------------------------------------------------------------------------
// rgbf_lane
// One color channel: level, target, signed step, serial step divider and the
// per-tick move decision.
// ----------------------------------------------------------------------------
module rgbf_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rgbf_pkg::lane_ctrl_t           ctrl,
	input  logic [rgbf_pkg::LEVEL_W-1:0]   col,
	input  logic [rgbf_pkg::DIV_W-1:0]     divisor,
	output logic [rgbf_pkg::LEVEL_W-1:0]   level,
	output logic                           move
);
	import rgbf_pkg::*;

	logic [LEVEL_W-1:0]        cur_q;
	logic [LEVEL_W-1:0]        tgt_q;
	logic signed [LEVEL_W-1:0] step_q;
	logic                      neg_q;
	logic [LEVEL_W-1:0]        dvd_q;
	logic [DIV_W-1:0]          rem_q;

	logic [DIV_W:0]     rem_sh;
	logic               ge;
	logic [DIV_W:0]     rem_sub;
	logic [DIV_W-1:0]   rem_nx;
	logic [LEVEL_W-1:0] dvd_nx;
	logic [LEVEL_W-2:0] sat;
	logic [LEVEL_W-1:0] step_nx;
	logic [LEVEL_W-1:0] mag;
	logic [LEVEL_W-1:0] remain;
	logic [LEVEL_W-1:0] smag;

	// one quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q, dvd_q[LEVEL_W-1]};
		ge      = rem_sh >= {1'b0, divisor};
		rem_sub = rem_sh - {1'b0, divisor};
		rem_nx  = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
		dvd_nx  = {dvd_q[LEVEL_W-2:0], ge};
		sat     = dvd_nx[LEVEL_W-1] ? STEP_MAX : dvd_nx[LEVEL_W-2:0];
		step_nx = neg_q ? (LEVEL_W'(0) - {1'b0, sat}) : {1'b0, sat};
	end

	always_comb begin
		mag    = (col < cur_q) ? (cur_q - col) : (col - cur_q);
		remain = (tgt_q < cur_q) ? (cur_q - tgt_q) : (tgt_q - cur_q);
		smag   = step_q[LEVEL_W-1] ? (LEVEL_W'(0) - step_q) : step_q;
		move   = (smag != '0) && (remain > smag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			tgt_q  <= '0;
			step_q <= '0;
		end else begin
			if (ctrl.set) begin
				cur_q <= col;
			end else if (ctrl.tick_apply) begin
				if (ctrl.snap) begin
					cur_q <= tgt_q;
				end else if (move) begin
					cur_q <= cur_q + step_q;
				end
			end
			if (ctrl.div_load) begin
				tgt_q <= col;
			end
			if (ctrl.div_last) begin
				step_q <= step_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			neg_q <= col < cur_q;
			dvd_q <= mag;
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
	end

	assign level = cur_q;

endmodule

[rtl/core/rgbf_merge.sv]
// ----------------------------------------------------------------------------
// rgbf_merge
// Combines the lanes: any-moved flag for the fade tick and gamma-corrected,
// inverted pwm compare values for the result.
// ----------------------------------------------------------------------------
module rgbf_merge (
	input  logic [rgbf_pkg::LEVEL_W-1:0]  level [rgbf_pkg::LANES],
	input  logic [rgbf_pkg::LANES-1:0]    move,
	output logic                          moved_any,
	output logic [rgbf_pkg::PWM_BITS-1:0] pwm [rgbf_pkg::LANES]
);
	import rgbf_pkg::*;

	assign moved_any = |move;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			pwm[i] = pwm_value(level[i]);
		end
	end

endmodule

[rtl/core/rgb_gamma_fade_controller_top.sv]
// ----------------------------------------------------------------------------
// rgb_gamma_fade_controller_top
// RGB LED fader: set, linear fade with per-channel serial step division,
// prescaled ticks, gamma-corrected inverted pwm results.
//
//   channel  signals                       transfer when
//   in       in_valid in_ready in_data     in_valid && in_ready
//   out      out_valid out_ready out_data  out_valid && out_ready
//   cfg      cfg_we cfg_wdata              cfg_we (tick_prescale)
//
// one item at a time; out_valid rises after the input transfer once the item
// has passed ST_EXEC and ST_OUT for set, tick and unused codes, and ST_EXEC,
// ST_DIV and ST_OUT for a fade, where the three lane dividers run in parallel
// in_ready is high only while no item is in progress
// a result waits in the output register; a stalled output holds the block
// arst_n clears levels, targets, steps, mode, tick count and prescale (to 2)
// ----------------------------------------------------------------------------
module rgb_gamma_fade_controller_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rgbf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rgbf_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);
	import rgbf_pkg::*;

	state_t             state_q, state_nx;
	mode_t              mode_q;
	in_item_t           item_q;
	logic [LEVEL_W-1:0] prescale_q;
	logic [LEVEL_W-1:0] ovf_cnt_q;
	logic [DIV_W-1:0]   div_q;
	logic [CNT_W-1:0]   step_cnt_q;
	logic               out_valid_q;
	out_item_t          out_q;

	cmd_t                      cmd;
	lane_ctrl_t                ctrl;
	logic [LEVEL_W-1:0]        col [LANES];
	logic [LEVEL_W-1:0]        level [LANES];
	logic [LANES-1:0]          move;
	logic                      moved_any;
	logic [PWM_BITS-1:0]       pwm [LANES];
	logic [TIME_W+RECIP_W-1:0] prod;
	logic [DIV_W-1:0]          div_raw;
	logic [LEVEL_W:0]          ovf_next;
	logic                      fire;
	logic                      out_load;
	logic                      last_step;

	assign cmd    = cmd_t'(item_q.command);
	assign col[0] = item_q.red_in;
	assign col[1] = item_q.green_in;
	assign col[2] = item_q.blue_in;

	// fade_time / 10 by reciprocal, exact over 16 bits
	assign prod    = TIME_W'(item_q.fade_time) * RECIP_TEN;
	assign div_raw = DIV_W'(prod >> RECIP_SHIFT);

	assign ovf_next  = {1'b0, ovf_cnt_q} + (LEVEL_W+1)'(1);
	assign fire      = ovf_next >= {1'b0, prescale_q};
	assign last_step = step_cnt_q == CNT_W'(DIV_STEPS - 1);
	assign out_load  = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nx = (cmd == CMD_FADE) ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (last_step) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: begin
				ctrl.set        = cmd == CMD_SET;
				ctrl.div_load   = cmd == CMD_FADE;
				ctrl.tick_apply = (cmd == CMD_TICK) && fire && (mode_q == MODE_FADE);
				ctrl.snap       = !moved_any;
			end
			ST_DIV: begin
				ctrl.div_step = 1'b1;
				ctrl.div_last = last_step;
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		rgbf_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.col     (col[i]),
			.divisor (div_q),
			.level   (level[i]),
			.move    (move[i])
		);
	end

	rgbf_merge u_merge (
		.level     (level),
		.move      (move),
		.moved_any (moved_any),
		.pwm       (pwm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_OFF;
			prescale_q  <= PRESCALE_RESET;
			ovf_cnt_q   <= '0;
			step_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				prescale_q <= cfg_wdata;
			end
			if (state_q == ST_EXEC) begin
				case (cmd)
					CMD_SET: mode_q <= MODE_IDLE;
					CMD_FADE: mode_q <= MODE_FADE;
					CMD_TICK: begin
						if (fire) begin
							ovf_cnt_q <= '0;
							if (mode_q == MODE_FADE && !moved_any) begin
								mode_q <= MODE_IDLE;
							end
						end else begin
							ovf_cnt_q <= ovf_next[LEVEL_W-1:0];
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_DIV) begin
				step_cnt_q <= last_step ? '0 : step_cnt_q + CNT_W'(1);
			end
			if (state_q == ST_OUT && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (state_q == ST_EXEC) begin
			div_q <= (div_raw == '0) ? DIV_W'(1) : div_raw;
		end
		if (state_q == ST_OUT && out_load) begin
			out_q.pwm_red   <= pwm[0];
			out_q.pwm_green <= pwm[1];
			out_q.pwm_blue  <= pwm[2];
			out_q.mode_out  <= mode_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
